// ===== hw/rtl/scafifo_pkg.sv =====
// Shared types, scan code constants and the set-1 translation tables
// for the scan code to character FIFO. No dependencies.
`default_nettype none

package scafifo_pkg;

  // Values of the kind field of a request transaction.
  localparam logic KIND_CODE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [7:0] SHIFT_L_MAKE  = 8'h2a;
  localparam logic [7:0] SHIFT_R_MAKE  = 8'h36;
  localparam logic [7:0] SHIFT_L_BREAK = 8'haa;
  localparam logic [7:0] SHIFT_R_BREAK = 8'hb6;
  localparam logic [7:0] LAST_MAKE     = 8'h80;

  typedef struct packed {
    logic       echo;
    logic [7:0] ch;
  } xl_t;

  typedef struct packed {
    logic pushed;
    logic dropped;
    logic popped;
  } st_t;

  function automatic logic [7:0] plain_char(input logic [7:0] code);
    logic [7:0] ch;
    case (code)
      8'h02: ch = "1";
      8'h03: ch = "2";
      8'h04: ch = "3";
      8'h05: ch = "4";
      8'h06: ch = "5";
      8'h07: ch = "6";
      8'h08: ch = "7";
      8'h09: ch = "8";
      8'h0a: ch = "9";
      8'h0b: ch = "0";
      8'h0c: ch = "-";
      8'h0d: ch = "=";
      8'h10: ch = "q";
      8'h11: ch = "w";
      8'h12: ch = "e";
      8'h13: ch = "r";
      8'h14: ch = "t";
      8'h15: ch = "z";
      8'h16: ch = "u";
      8'h17: ch = "i";
      8'h18: ch = "o";
      8'h19: ch = "p";
      8'h1a: ch = "[";
      8'h1b: ch = "]";
      8'h1c: ch = 8'h0a;
      8'h1e: ch = "a";
      8'h1f: ch = "s";
      8'h20: ch = "d";
      8'h21: ch = "f";
      8'h22: ch = "g";
      8'h23: ch = "h";
      8'h24: ch = "j";
      8'h25: ch = "k";
      8'h26: ch = "l";
      8'h27: ch = ";";
      8'h28: ch = 8'h27;
      8'h2c: ch = "y";
      8'h2d: ch = "x";
      8'h2e: ch = "c";
      8'h2f: ch = "v";
      8'h30: ch = "b";
      8'h31: ch = "n";
      8'h32: ch = "m";
      8'h33: ch = ",";
      8'h34: ch = ".";
      8'h35: ch = "/";
      8'h39: ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] upper_char(input logic [7:0] code);
    logic [7:0] ch;
    case (code)
      8'h02: ch = "!";
      8'h03: ch = "@";
      8'h04: ch = "#";
      8'h05: ch = "$";
      8'h06: ch = "%";
      8'h07: ch = "^";
      8'h08: ch = "&";
      8'h09: ch = "*";
      8'h0a: ch = "(";
      8'h0b: ch = ")";
      8'h0c: ch = "_";
      8'h0d: ch = "+";
      8'h10: ch = "Q";
      8'h11: ch = "W";
      8'h12: ch = "E";
      8'h13: ch = "R";
      8'h14: ch = "T";
      8'h15: ch = "Z";
      8'h16: ch = "U";
      8'h17: ch = "I";
      8'h18: ch = "O";
      8'h19: ch = "P";
      8'h1a: ch = "{";
      8'h1b: ch = "}";
      8'h1e: ch = "A";
      8'h1f: ch = "S";
      8'h20: ch = "D";
      8'h21: ch = "F";
      8'h22: ch = "G";
      8'h23: ch = "H";
      8'h24: ch = "J";
      8'h25: ch = "K";
      8'h26: ch = "L";
      8'h27: ch = ":";
      8'h28: ch = 8'h22;
      8'h2c: ch = "Y";
      8'h2d: ch = "X";
      8'h2e: ch = "C";
      8'h2f: ch = "V";
      8'h30: ch = "B";
      8'h31: ch = "N";
      8'h32: ch = "M";
      8'h33: ch = "<";
      8'h34: ch = ">";
      8'h35: ch = "?";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scafifo_req_if.sv =====
// Request channel: a scan code or a read request, valid/ready handshake.
// No dependencies.
`default_nettype none

interface scafifo_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] scancode;

  modport source (output valid, output kind, output scancode, input ready);
  modport sink   (input valid, input kind, input scancode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scafifo_rsp_if.sv =====
// Response channel: echo, read and drop fields, valid/ready handshake.
// No dependencies.
`default_nettype none

interface scafifo_rsp_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic       read_valid;
  logic [7:0] read_char;
  logic       dropped;

  modport source (output valid, output echo_valid, output echo_char,
                  output read_valid, output read_char, output dropped, input ready);
  modport sink   (input valid, input echo_valid, input echo_char,
                  input read_valid, input read_char, input dropped, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scafifo_xlate.sv =====
// Shift tracking and set-1 translation of one scan code.
// Depends on scafifo_pkg.
`default_nettype none

module scafifo_xlate
  import scafifo_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] code,
  output xl_t        xl
);

  logic shift_held;
  logic is_make;
  logic is_break;

  always_comb begin
    is_make  = code inside {SHIFT_L_MAKE, SHIFT_R_MAKE};
    is_break = code inside {SHIFT_L_BREAK, SHIFT_R_BREAK};
    xl.echo  = !is_make && (code <= LAST_MAKE);
    xl.ch    = shift_held ? upper_char(code) : plain_char(code);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
    end else if (fire && is_make) begin
      shift_held <= 1'b1;
    end else if (fire && is_break) begin
      shift_held <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scafifo_store.sv =====
// Character ring buffer: one synchronous memory plus pointers and fill count.
// Depends on scafifo_pkg.
`default_nettype none

module scafifo_store
  import scafifo_pkg::*;
#(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] wdata,
  input  logic       pop,
  output st_t        st,
  output logic [7:0] rdata
);

  localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUFFER_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push_ok;
  logic          pop_ok;

  always_comb begin
    push_ok    = push && (count != FULL_CNT);
    pop_ok     = pop && (count != '0);
    st.pushed  = push_ok;
    st.dropped = push && !push_ok;
    st.popped  = pop_ok;
  end

  // A pop only reaches an entry whose write finished at an earlier edge,
  // so the same entry is never written and read in one cycle.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
    if (pop_ok) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
        count  <= count + 1'b1;
      end else if (pop_ok) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
        count  <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("fill count above buffer depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> count == $past(count) + 1'b1) else $error("push did not raise count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> count == $past(count) - 1'b1) else $error("pop did not lower count");

  a_ptr_wrap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FULL_CNT) |-> wr_ptr == rd_ptr)
    else $error("pointers disagree with empty or full count");

endmodule

`default_nettype wire

// ===== hw/rtl/scancode_to_ascii_fifo_top.sv =====
// Top level of the scan code to character FIFO: handshake, result pipeline.
// Depends on scafifo_pkg, scafifo_req_if, scafifo_rsp_if, scafifo_xlate, scafifo_store.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    kind, scancode
//  rsp      out  valid/ready    echo_valid, echo_char, read_valid, read_char, dropped
//
// One transaction per cycle is accepted while rsp is not stalled. Its result
// passes through the buffer memory read stage and then the output register, from
// which it is presented on rsp.
// Synchronous reset clears shift state, pointers, count and valid flags; the
// character memory is not cleared and no clearing pass runs.
// When rsp stalls, the output register and the read stage hold one result
// each, and req stays ready until both are occupied.
`default_nettype none

module scancode_to_ascii_fifo_top
  import scafifo_pkg::*;
#(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,
  scafifo_req_if.sink     req,
  scafifo_rsp_if.source   rsp
);

  xl_t        xl;
  st_t        st;
  logic [7:0] rdata;
  logic       acc;
  logic       is_code;
  logic       push;
  logic       pop;
  logic       move;

  logic       s1_valid;
  logic       s1_echo;
  logic [7:0] s1_ch;
  logic       s1_pop;
  logic       s1_drop;

  logic       out_valid;
  logic       out_echo_valid;
  logic [7:0] out_echo_char;
  logic       out_read_valid;
  logic [7:0] out_read_char;
  logic       out_dropped;

  always_comb begin
    move      = s1_valid && (!out_valid || rsp.ready);
    req.ready = !s1_valid || move;
    acc       = req.valid && req.ready;
    is_code   = (req.kind == KIND_CODE);
    push      = acc && is_code && xl.echo;
    pop       = acc && (req.kind == KIND_READ);
  end

  scafifo_xlate u_xlate (
    .clk  (clk),
    .rst  (rst),
    .fire (acc && is_code),
    .code (req.scancode),
    .xl   (xl)
  );

  scafifo_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (xl.ch),
    .pop   (pop),
    .st    (st),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_echo <= is_code && xl.echo;
      s1_ch   <= (is_code && xl.echo) ? xl.ch : 8'h00;
      s1_pop  <= st.popped;
      s1_drop <= st.dropped;
    end
  end

  // The memory read data belongs to the item in the read stage until it moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_echo_valid <= s1_echo;
      out_echo_char  <= s1_ch;
      out_read_valid <= s1_pop;
      out_read_char  <= s1_pop ? rdata : 8'h00;
      out_dropped    <= s1_drop;
    end
  end

  always_comb begin
    rsp.valid      = out_valid;
    rsp.echo_valid = out_echo_valid;
    rsp.echo_char  = out_echo_char;
    rsp.read_valid = out_read_valid;
    rsp.read_char  = out_read_char;
    rsp.dropped    = out_dropped;
  end

endmodule

`default_nettype wire

// ===== test/tb_scancode_to_ascii_fifo_top.sv =====
// Self-checking testbench for scancode_to_ascii_fifo_top: directed table, then random traffic.
// Scan codes and read requests go in, echo/read/drop results are checked against a predictor.
// Depends on scafifo_pkg, scafifo_req_if, scafifo_rsp_if and the DUT sources.
`timescale 1ns / 1ps

module tb_scancode_to_ascii_fifo_top;
  import scafifo_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       read_valid;
    logic [7:0] read_char;
    logic       dropped;
  } key_result_t;

  typedef struct {
    logic        kind;
    logic [7:0]  code;
    bit          typed_in;
    key_result_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  scafifo_req_if req_ch ();
  scafifo_rsp_if rsp_ch ();

  scancode_to_ascii_fifo_top #(
    .BUFFER_DEPTH(STORE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Predictor state of the keyboard front end.
  logic        shift_down;
  logic [7:0]  typed_chars [STORE_DEPTH];
  logic [7:0]  head_idx;
  logic [7:0]  tail_idx;
  int          chars_held;

  key_result_t pending_results [$];
  stim_row_t   dir_rows [$];
  int          error_count;
  bit          quiet_tail;

  // Travels with each request so the monitor knows whether a typed-in result applies.
  bit          row_typed;
  key_result_t row_want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Set-1 translation, one keyboard row per string.
  function automatic logic [7:0] key_char(input logic [7:0] code, input logic upper);
    string row;
    int    base;
    logic [7:0] ch;
    row = "";
    base = 0;
    ch = 8'h00;
    if (code >= 8'h02 && code <= 8'h0d) begin
      base = 'h02;
      if (upper) row = "!@#$%^&*()_+";
      else row = "1234567890-=";
    end else if (code >= 8'h10 && code <= 8'h1b) begin
      base = 'h10;
      if (upper) row = "QWERTZUIOP{}";
      else row = "qwertzuiop[]";
    end else if (code >= 8'h1e && code <= 8'h28) begin
      base = 'h1e;
      if (upper) row = "ASDFGHJKL:\"";
      else row = "asdfghjkl;'";
    end else if (code >= 8'h2c && code <= 8'h35) begin
      base = 'h2c;
      if (upper) row = "YXCVBNM<>?";
      else row = "yxcvbnm,./";
    end
    if (row.len() > 0) ch = row[int'(code) - base];
    else if (code == 8'h1c && !upper) ch = 8'h0a;
    else if (code == 8'h39 && !upper) ch = 8'h20;
    return ch;
  endfunction

  // Advances the predictor by one accepted request and returns its result.
  function automatic key_result_t predict_key(input logic kind, input logic [7:0] code);
    key_result_t res;
    logic [7:0]  ch;
    res = '0;
    if (kind == KIND_READ) begin
      if (chars_held != 0) begin
        res.read_valid = 1'b1;
        res.read_char = typed_chars[head_idx];
        head_idx = head_idx + 8'd1;
        chars_held--;
      end
    end else if (code == SHIFT_L_MAKE || code == SHIFT_R_MAKE) begin
      shift_down = 1'b1;
    end else if (code == SHIFT_L_BREAK || code == SHIFT_R_BREAK) begin
      shift_down = 1'b0;
    end else if (code <= LAST_MAKE) begin
      ch = key_char(code, shift_down);
      res.echo_valid = 1'b1;
      res.echo_char = ch;
      if (chars_held == STORE_DEPTH) begin
        res.dropped = 1'b1;
      end else begin
        typed_chars[tail_idx] = ch;
        tail_idx = tail_idx + 8'd1;
        chars_held++;
      end
    end
    return res;
  endfunction

  function automatic key_result_t echoed(input logic [7:0] ch);
    key_result_t res;
    res = '0;
    res.echo_valid = 1'b1;
    res.echo_char = ch;
    return res;
  endfunction

  function automatic key_result_t popped(input logic [7:0] ch);
    key_result_t res;
    res = '0;
    res.read_valid = 1'b1;
    res.read_char = ch;
    return res;
  endfunction

  function automatic void add_row(input logic kind, input logic [7:0] code,
                                  input bit typed_in, input key_result_t want);
    stim_row_t row;
    row.kind = kind;
    row.code = code;
    row.typed_in = typed_in;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: code = SHIFT_L_MAKE;
        1: code = SHIFT_R_MAKE;
        2: code = SHIFT_L_BREAK;
        default: code = SHIFT_R_BREAK;
      endcase
    end else if (r < 18) begin
      code = 8'($urandom_range(LAST_MAKE + 1, 8'hff));
    end else if (r < 30) begin
      code = 8'($urandom_range(0, LAST_MAKE));
    end else begin
      code = 8'($urandom_range(8'h02, 8'h39));
    end
    return code;
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] code,
                           input bit typed_in = 1'b0, input key_result_t want = '0);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.scancode <= code;
    row_typed <= typed_in;
    row_want <= want;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // A shift press, a short burst of keys, and a release (either side).
  task automatic send_shifted_word(output int count);
    int len;
    len = $urandom_range(1, 5);
    send_item(KIND_CODE, $urandom_range(0, 1) ? SHIFT_L_MAKE : SHIFT_R_MAKE);
    repeat (len) send_item(KIND_CODE, 8'($urandom_range(8'h02, 8'h39)));
    send_item(KIND_CODE, $urandom_range(0, 1) ? SHIFT_L_BREAK : SHIFT_R_BREAK);
    count = len + 2;
  endtask

  task automatic run_mix(input int n, input int read_pct);
    int sent;
    int r;
    int word_len;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < read_pct) begin
        send_item(KIND_READ, 8'($urandom_range(0, 255)));
        sent++;
      end else if (r < read_pct + 8) begin
        send_shifted_word(word_len);
        sent += word_len;
      end else begin
        send_item(KIND_CODE, pick_code());
        sent++;
      end
    end
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver side: random stall bursts, none in the tail.
  initial begin : rsp_stall
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (quiet_tail || rst) begin
        stall_left = 0;
        rsp_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Predicts on every accepted request and checks every accepted result.
  always @(posedge clk) begin : monitor
    key_result_t exp_res;
    key_result_t got_res;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        exp_res = predict_key(req_ch.kind, req_ch.scancode);
        if (row_typed) exp_res = row_want;
        pending_results.push_back(exp_res);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_res.echo_valid = rsp_ch.echo_valid;
        got_res.echo_char = rsp_ch.echo_char;
        got_res.read_valid = rsp_ch.read_valid;
        got_res.read_char = rsp_ch.read_char;
        got_res.dropped = rsp_ch.dropped;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %h", $realtime, got_res);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (got_res.echo_valid !== exp_res.echo_valid) begin
            $display("%0t: echo_valid expected %h actual %h", $realtime,
                     exp_res.echo_valid, got_res.echo_valid);
            error_count++;
          end
          if (got_res.echo_char !== exp_res.echo_char) begin
            $display("%0t: echo_char expected %h actual %h", $realtime,
                     exp_res.echo_char, got_res.echo_char);
            error_count++;
          end
          if (got_res.read_valid !== exp_res.read_valid) begin
            $display("%0t: read_valid expected %h actual %h", $realtime,
                     exp_res.read_valid, got_res.read_valid);
            error_count++;
          end
          if (got_res.read_char !== exp_res.read_char) begin
            $display("%0t: read_char expected %h actual %h", $realtime,
                     exp_res.read_char, got_res.read_char);
            error_count++;
          end
          if (got_res.dropped !== exp_res.dropped) begin
            $display("%0t: dropped expected %h actual %h", $realtime,
                     exp_res.dropped, got_res.dropped);
            error_count++;
          end
        end
      end
    end
  end

  // Ends the run when neither channel has moved a transaction for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("tb_scancode_to_ascii_fifo_top: errors");
    $finish;
  end

  initial begin : stimulus
    shift_down = 1'b0;
    head_idx = '0;
    tail_idx = '0;
    chars_held = 0;
    error_count = 0;
    quiet_tail = 1'b0;
    rst = 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_CODE;
    req_ch.scancode <= 8'h00;
    row_typed <= 1'b0;
    row_want <= '0;

    // Empty read, unmapped codes, shift on both sides, ignored breaks, then drain.
    add_row(KIND_READ, 8'hff, 1'b1, '0);
    add_row(KIND_CODE, 8'h00, 1'b1, echoed(8'h00));
    add_row(KIND_CODE, LAST_MAKE, 1'b1, echoed(8'h00));
    add_row(KIND_CODE, 8'h1e, 1'b1, echoed("a"));
    add_row(KIND_CODE, SHIFT_L_MAKE, 1'b1, '0);
    add_row(KIND_CODE, 8'h1e, 1'b1, echoed("A"));
    add_row(KIND_CODE, 8'h1c, 1'b1, echoed(8'h00));
    add_row(KIND_CODE, SHIFT_L_BREAK, 1'b1, '0);
    add_row(KIND_CODE, 8'h1c, 1'b1, echoed(8'h0a));
    add_row(KIND_CODE, SHIFT_R_MAKE, 1'b1, '0);
    add_row(KIND_CODE, 8'h02, 1'b1, echoed("!"));
    add_row(KIND_CODE, SHIFT_R_BREAK, 1'b1, '0);
    add_row(KIND_CODE, 8'h81, 1'b1, '0);
    add_row(KIND_CODE, 8'hff, 1'b1, '0);
    add_row(KIND_CODE, 8'h39, 1'b1, echoed(" "));
    add_row(KIND_READ, 8'h00, 1'b1, popped(8'h00));
    add_row(KIND_READ, 8'h55, 1'b0, '0);
    add_row(KIND_READ, 8'haa, 1'b0, '0);
    add_row(KIND_READ, 8'h0f, 1'b0, '0);
    add_row(KIND_READ, 8'hf0, 1'b0, '0);
    add_row(KIND_READ, 8'h80, 1'b0, '0);
    add_row(KIND_READ, 8'h01, 1'b0, '0);
    add_row(KIND_READ, 8'h7f, 1'b0, '0);
    add_row(KIND_READ, 8'hff, 1'b1, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].code, dir_rows[i].typed_in, dir_rows[i].want);

    // Fill past capacity so that drops occur and the write index wraps.
    repeat (266) send_item(KIND_CODE, 8'($urandom_range(0, LAST_MAKE)));
    // Mostly reads; with the tail below the read index wraps as well.
    run_mix(200, 95);
    hold_until_drained();
    quiet_tail = 1'b1;
    run_mix(70, 90);

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb_scancode_to_ascii_fifo_top: clean");
    else
      $display("tb_scancode_to_ascii_fifo_top: errors");
    $finish;
  end

endmodule
